/* hw/rtl/ddct_pkg.sv */
// ----------------------------------------------------------------------------
// ddct_pkg
// Types, register offsets and constants shared by the dual down-counter timer.
// ----------------------------------------------------------------------------
package ddct_pkg;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [4:0] REG_LOAD   = 5'h00;
	localparam logic [4:0] REG_VALUE  = 5'h04;
	localparam logic [4:0] REG_CTRL   = 5'h08;
	localparam logic [4:0] REG_INTCLR = 5'h0C;
	localparam logic [4:0] REG_RIS    = 5'h10;
	localparam logic [4:0] REG_MIS    = 5'h14;
	localparam logic [4:0] REG_BGLOAD = 5'h18;

	localparam logic [11:0] OFF_CLKSEL  = 12'h080;
	localparam logic [11:0] OFF_ID_BASE = 12'hFE0;

	localparam int CTL_ONESHOT_BIT  = 0;
	localparam int CTL_WIDE_BIT     = 1;
	localparam int CTL_IE_BIT       = 5;
	localparam int CTL_PERIODIC_BIT = 6;
	localparam int CTL_ENABLE_BIT   = 7;

	localparam logic [7:0]  CTL_WRITE_MASK = 8'hEF;
	localparam logic [7:0]  CTL_RESET      = 8'h20;
	localparam logic [31:0] MASK_16        = 32'h0000_FFFF;
	localparam logic [31:0] MASK_32        = 32'hFFFF_FFFF;
	localparam logic [1:0]  CLKSEL_MASK    = 2'h3;

	localparam logic [1:0] PRESC_DIV16  = 2'd1;
	localparam logic [1:0] PRESC_DIV256 = 2'd2;

	localparam logic [2:0] CFG_ADDR_FAST = 3'd0;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] offset;
		logic [31:0] write_data;
	} ddct_in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
	} ddct_out_t;

	typedef struct packed {
		logic        tick;
		logic        wr;
		logic [4:0]  reg_off;
		logic [31:0] data;
	} ddct_tmr_cmd_t;

	typedef struct packed {
		logic [31:0] reload;
		logic [31:0] value;
		logic [7:0]  ctl;
		logic        raw;
		logic        irq_nx;
	} ddct_tmr_stat_t;

	function automatic logic [7:0] ddct_id_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h04;
			3'd1:    b = 8'h18;
			3'd2:    b = 8'h14;
			3'd3:    b = 8'h00;
			3'd4:    b = 8'h0D;
			3'd5:    b = 8'hF0;
			3'd6:    b = 8'h05;
			default: b = 8'hB1;
		endcase
		return b;
	endfunction

endpackage

/* hw/rtl/ddct_timer.sv */
// ----------------------------------------------------------------------------
// ddct_timer
// One down-counting timer: prescaler, counter, reload, control and raw status.
// ----------------------------------------------------------------------------
module ddct_timer (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ddct_pkg::ddct_tmr_cmd_t  cmd,
	output ddct_pkg::ddct_tmr_stat_t stat
);
	import ddct_pkg::*;

	logic [31:0] reload_q, reload_d;
	logic [31:0] count_q, count_d;
	logic [7:0]  ctl_q, ctl_d;
	logic [7:0]  presc_q, presc_d;
	logic        raw_q, raw_d;
	logic        pend_q, pend_d;

	logic [31:0] mask;
	logic [31:0] cnt_base;
	logic [31:0] cnt_masked;
	logic [8:0]  presc_inc;
	logic        expire;

	assign mask       = ctl_q[CTL_WIDE_BIT] ? MASK_32 : MASK_16;
	assign cnt_base   = pend_q ? (reload_q & mask) : count_q;
	assign cnt_masked = cnt_base & mask;
	assign presc_inc  = {1'b0, presc_q} + 9'd1;

	always_comb begin
		case (ctl_q[3:2])
			PRESC_DIV16:  expire = (presc_inc >= 9'd16);
			PRESC_DIV256: expire = (presc_inc >= 9'd256);
			default:      expire = 1'b1;
		endcase
	end

	always_comb begin
		reload_d = reload_q;
		count_d  = count_q;
		ctl_d    = ctl_q;
		presc_d  = presc_q;
		raw_d    = raw_q;
		pend_d   = pend_q;
		if (cmd.tick && ctl_q[CTL_ENABLE_BIT]) begin
			pend_d  = 1'b0;
			count_d = cnt_base;
			if (expire) begin
				presc_d = '0;
				if (cnt_masked == '0) begin
					raw_d = 1'b1;
					if (ctl_q[CTL_ONESHOT_BIT])
						ctl_d[CTL_ENABLE_BIT] = 1'b0;
					else if (ctl_q[CTL_PERIODIC_BIT])
						count_d = reload_q & mask;
					else
						count_d = mask;
				end else begin
					count_d = (cnt_masked - 32'd1) & mask;
				end
			end else begin
				presc_d = presc_inc[7:0];
			end
		end else if (cmd.wr) begin
			case (cmd.reg_off)
				REG_LOAD: begin
					reload_d = cmd.data;
					pend_d   = 1'b1;
				end
				REG_CTRL:   ctl_d    = cmd.data[7:0] & CTL_WRITE_MASK;
				REG_INTCLR: raw_d    = 1'b0;
				REG_BGLOAD: reload_d = cmd.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= '0;
			count_q  <= MASK_32;
			ctl_q    <= CTL_RESET;
			presc_q  <= '0;
			raw_q    <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			reload_q <= reload_d;
			count_q  <= count_d;
			ctl_q    <= ctl_d;
			presc_q  <= presc_d;
			raw_q    <= raw_d;
			pend_q   <= pend_d;
		end
	end

	assign stat.reload = reload_q;
	assign stat.value  = count_q & mask;
	assign stat.ctl    = ctl_q;
	assign stat.raw    = raw_q;
	assign stat.irq_nx = raw_d & ctl_d[CTL_IE_BIT];

	a_count_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.tick |=> $stable(count_q))
		else $error("counter moved without a tick");

	a_presc_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.tick |=> $stable(presc_q))
		else $error("prescaler moved without a tick");

	a_div1_presc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick && ctl_q[CTL_ENABLE_BIT] && ctl_q[3:2] != PRESC_DIV16
		&& ctl_q[3:2] != PRESC_DIV256 |=> presc_q == '0)
		else $error("divide-by-one prescaler not at zero");

endmodule

/* hw/rtl/dual_down_counter_timer.sv */
// ----------------------------------------------------------------------------
// dual_down_counter_timer
// Two down-counting timers fed by a stream of ticks and register accesses.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data  (kind, offset, write_data)
//  out     | output    | out_valid/out_stall| out_data (read_data, irq)
//  apb     | input     | psel/penable/pready| paddr, pwdata, prdata
//
//  One beat per cycle sustained unless the result stalls; a beat is held in
//  an input register, its timer updates and read data resolve in one pass,
//  then the result register holds it. The result register bounds the rate.
//  Reset: reload words zero, control 0x20, counters all ones; no clearing pass.
//  A stalled result holds; the input register keeps accepting while the
//  result register is empty or being taken.
// ----------------------------------------------------------------------------
module dual_down_counter_timer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ddct_pkg::ddct_in_t in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ddct_pkg::ddct_out_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import ddct_pkg::*;

	logic           s1_valid;
	ddct_in_t       s1_data;
	logic           adv;
	logic           fast_q;
	logic [1:0]     clk_sel_q;
	logic           lo_space;
	logic [31:0]    rd;
	ddct_tmr_cmd_t  cmd [2];
	ddct_tmr_stat_t stat [2];
	ddct_tmr_stat_t sel_stat;

	assign pready = 1'b1;
	assign prdata = {31'b0, fast_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fast_q <= 1'b0;
		else if (psel && penable && pwrite && pready && paddr == CFG_ADDR_FAST)
			fast_q <= pwdata[0];
	end

	assign adv      = s1_valid && (!out_valid || !out_stall);
	assign in_stall = s1_valid && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (!in_stall)
			s1_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			s1_data <= in_data;
	end

	assign lo_space = (s1_data.offset[11:6] == 6'd0);

	for (genvar g = 0; g < 2; g++) begin : g_tmr
		assign cmd[g].tick    = adv && s1_data.kind == KIND_TICK;
		assign cmd[g].wr      = adv && s1_data.kind == KIND_WRITE && lo_space
		                        && s1_data.offset[5] == 1'(g);
		assign cmd[g].reg_off = s1_data.offset[4:0];
		assign cmd[g].data    = s1_data.write_data;

		ddct_timer u_timer (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[g]),
			.stat   (stat[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clk_sel_q <= '0;
		else if (adv && s1_data.kind == KIND_WRITE && s1_data.offset == OFF_CLKSEL && fast_q)
			clk_sel_q <= s1_data.write_data[1:0] & CLKSEL_MASK;
	end

	assign sel_stat = stat[s1_data.offset[5]];

	always_comb begin
		rd = '0;
		if (s1_data.kind == KIND_READ) begin
			if (lo_space) begin
				case (s1_data.offset[4:0])
					REG_LOAD:  rd = sel_stat.reload;
					REG_VALUE: rd = sel_stat.value;
					REG_CTRL:  rd = {24'b0, sel_stat.ctl};
					REG_RIS:   rd = {31'b0, sel_stat.raw};
					REG_MIS:   rd = {31'b0, sel_stat.raw & sel_stat.ctl[CTL_IE_BIT]};
					default:   rd = '0;
				endcase
			end else if (s1_data.offset == OFF_CLKSEL) begin
				rd = fast_q ? {30'b0, clk_sel_q} : '0;
			end else if (s1_data.offset >= OFF_ID_BASE && s1_data.offset[1:0] == 2'b00) begin
				rd = {24'b0, ddct_id_byte(s1_data.offset[4:2])};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.read_data <= rd;
			out_data.irq       <= stat[0].irq_nx | stat[1].irq_nx;
		end
	end

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("processed beat did not reach the result register");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !adv |=> s1_valid && $stable(s1_data))
		else $error("waiting input beat lost or changed");

	a_out_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_no_adv_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !adv)
		else $error("beat processed over a stalled result");

endmodule
